[hdl/detection_anchor_decode_defines.svh]
// Assertion macros for the checker file of the anchor decoder.
`ifndef DETECTION_ANCHOR_DECODE_DEFINES_SVH
`define DETECTION_ANCHOR_DECODE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, held off during reset.
`define DAD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, held off during reset.
`define DAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/dad_pkg.sv]
// Shared widths, register indexes, reset values and stage types of the anchor decoder.
package dad_pkg;

   localparam int VALUE_W   = 32;
   localparam int POS_W     = 8;
   localparam int CLASS_W   = 7;
   localparam int CONF_W    = 31;
   localparam int THRESH_W  = 17;
   localparam int PAD_W     = 31;
   localparam int SCALE_W   = 24;
   localparam int PIXEL_W   = 16;
   localparam int FRAC_W    = 16;
   localparam int LABEL_W   = 8;
   localparam int EDGE_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // centre minus padding, doubled, plus or minus the size
   localparam int TWICE_W   = VALUE_W + 3;
   localparam int PROD_W    = TWICE_W + SCALE_W + 1;
   localparam int SHIFT_W   = FRAC_W + 1;
   localparam int SCALED_W  = PROD_W - SHIFT_W;

   localparam int BOX_CHANNELS = 4;
   localparam int MAX_LABELS   = 128;
   localparam logic [POS_W-1:0]   POS_FIRST_CLASS = POS_W'(BOX_CHANNELS);
   localparam logic [POS_W-1:0]   POS_SATURATED   = {POS_W{1'b1}};
   localparam logic [LABEL_W-1:0] LABELS_CAP      = LABEL_W'(MAX_LABELS);

   localparam logic [POS_W-1:0] POS_CENTER_X = POS_W'(0);
   localparam logic [POS_W-1:0] POS_CENTER_Y = POS_W'(1);
   localparam logic [POS_W-1:0] POS_WIDTH    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_HEIGHT   = POS_W'(3);

   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_OFFSET_X    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_OFFSET_Y    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_BACK      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_LABEL_COUNT     = CSR_IDX_W'(6);

   localparam logic [THRESH_W-1:0] RST_SCORE_THRESHOLD = THRESH_W'(16384);
   localparam logic [PAD_W-1:0]    RST_PAD_OFFSET      = '0;
   localparam logic [SCALE_W-1:0]  RST_SCALE_BACK      = SCALE_W'(65536);
   localparam logic [PIXEL_W-1:0]  RST_IMAGE_SIZE      = PIXEL_W'(640);
   localparam logic [LABEL_W-1:0]  RST_LABEL_COUNT     = LABEL_W'(80);

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [CONF_W-1:0]  conf;
   } meta_type;

   typedef struct packed {
      logic [TWICE_W-1:0] x_near;
      logic [TWICE_W-1:0] x_far;
      logic [TWICE_W-1:0] y_near;
      logic [TWICE_W-1:0] y_far;
      meta_type           meta;
   } job_type;

   typedef struct packed {
      logic [PROD_W-1:0] x_near;
      logic [PROD_W-1:0] x_far;
      logic [PROD_W-1:0] y_near;
      logic [PROD_W-1:0] y_far;
      meta_type          meta;
   } prod_type;

   typedef struct packed {
      logic [EDGE_W-1:0] x_near;
      logic [EDGE_W-1:0] x_far;
      logic [EDGE_W-1:0] y_near;
      logic [EDGE_W-1:0] y_far;
      meta_type          meta;
   } corner_type;

endpackage

[hdl/detection_anchor_decode.sv]
// Anchor-row decoder: streaming argmax over class scores and box corner scaling.
//
// One channel value is taken per clock while req_stall is low; a beat with
// req_row_end closes the anchor row. Channels 0 to 3 are the box, the following
// label_count channels (at most 128) are scores, later channels are ignored. A
// row whose best score is strictly above score_threshold yields one result beat
// through four registered stages: row capture (doubled corners), scale multiply
// (four 35x25 products), shift and clamp, corner differences. The input never
// stalls while rsp_stall is low; with rsp_stall held, up to four results are
// buffered in the stages before req_stall rises. csr_ready is always high;
// registers should be written only when no row is in flight.
module detection_anchor_decode
   import dad_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [VALUE_W-1:0]   req_channel_value,
   input  logic                        req_row_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [EDGE_W-1:0]           rsp_left_edge,
   output logic [EDGE_W-1:0]           rsp_top_edge,
   output logic [EDGE_W-1:0]           rsp_box_width,
   output logic [EDGE_W-1:0]           rsp_box_height,
   output logic [CLASS_W-1:0]          rsp_class_index,
   output logic [CONF_W-1:0]           rsp_confidence,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_data
);

   function automatic logic [EDGE_W-1:0] clamp_corner(
      input logic [PROD_W-1:0]  prod,
      input logic [PIXEL_W-1:0] limit_px
   );
      logic [SCALED_W-1:0] scaled;
      logic [EDGE_W-1:0]   lim;
      begin
         scaled = prod[PROD_W-1:SHIFT_W];
         lim    = {limit_px, {FRAC_W{1'b0}}};
         if ($signed(prod) <= 0) begin
            clamp_corner = '0;
         end else if (scaled > SCALED_W'(lim)) begin
            clamp_corner = lim;
         end else begin
            clamp_corner = scaled[EDGE_W-1:0];
         end
      end
   endfunction

   function automatic logic [EDGE_W-1:0] span(
      input logic [EDGE_W-1:0] near_edge,
      input logic [EDGE_W-1:0] far_edge
   );
      begin
         span = (far_edge > near_edge) ? far_edge - near_edge : '0;
      end
   endfunction

   // configuration registers
   logic [THRESH_W-1:0] thresh_ff;
   logic [PAD_W-1:0]    pad_x_ff;
   logic [PAD_W-1:0]    pad_y_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [PIXEL_W-1:0]  img_w_ff;
   logic [PIXEL_W-1:0]  img_h_ff;
   logic [LABEL_W-1:0]  labels_ff;

   // row state
   logic [POS_W-1:0]    pos_ff,   pos_in;
   logic [VALUE_W-1:0]  max_ff,   max_in;
   logic [CLASS_W-1:0]  cls_ff,   cls_in;
   logic [VALUE_W-1:0]  cx_ff,    cx_in;
   logic [VALUE_W-1:0]  cy_ff,    cy_in;
   logic [VALUE_W-1:0]  w_ff,     w_in;
   logic [VALUE_W-1:0]  h_ff,     h_in;

   // stages
   logic       job_v_ff,  job_v_in;
   job_type    job_ff,    job_in;
   logic       prod_v_ff, prod_v_in;
   prod_type   prod_ff,   prod_in;
   logic       crn_v_ff,  crn_v_in;
   corner_type crn_ff,    crn_in;
   logic       rsp_v_ff,  rsp_v_in;
   logic [EDGE_W-1:0]  left_ff,  left_in;
   logic [EDGE_W-1:0]  top_ff,   top_in;
   logic [EDGE_W-1:0]  bw_ff,    bw_in;
   logic [EDGE_W-1:0]  bh_ff,    bh_in;
   meta_type           meta_ff,  meta_in;

   logic out_free, crn_move, crn_free, prod_move, prod_free, job_move, job_free;
   logic req_accept, csr_write;
   logic [LABEL_W-1:0]  labels_used;
   logic [POS_W-1:0]    class_offset;
   logic                is_class, take, pass, job_load;
   logic [VALUE_W-1:0]  max_upd;
   logic [CLASS_W-1:0]  cls_upd;
   logic signed [VALUE_W:0]   cx_rel, cy_rel;
   logic signed [TWICE_W-1:0] twice_cx, twice_cy, size_w, size_h;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= RST_SCORE_THRESHOLD;
         pad_x_ff  <= RST_PAD_OFFSET;
         pad_y_ff  <= RST_PAD_OFFSET;
         scale_ff  <= RST_SCALE_BACK;
         img_w_ff  <= RST_IMAGE_SIZE;
         img_h_ff  <= RST_IMAGE_SIZE;
         labels_ff <= RST_LABEL_COUNT;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCORE_THRESHOLD: thresh_ff <= csr_data[THRESH_W-1:0];
            CSR_PAD_OFFSET_X:    pad_x_ff  <= csr_data[PAD_W-1:0];
            CSR_PAD_OFFSET_Y:    pad_y_ff  <= csr_data[PAD_W-1:0];
            CSR_SCALE_BACK:      scale_ff  <= csr_data[SCALE_W-1:0];
            CSR_IMAGE_WIDTH:     img_w_ff  <= csr_data[PIXEL_W-1:0];
            CSR_IMAGE_HEIGHT:    img_h_ff  <= csr_data[PIXEL_W-1:0];
            CSR_LABEL_COUNT:     labels_ff <= csr_data[LABEL_W-1:0];
            default: ;
         endcase
      end
   end

   // stage flow, from the output back
   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign crn_move  = crn_v_ff && out_free;
   assign crn_free  = !crn_v_ff || out_free;
   assign prod_move = prod_v_ff && crn_free;
   assign prod_free = !prod_v_ff || crn_free;
   assign job_move  = job_v_ff && prod_free;
   assign job_free  = !job_v_ff || prod_free;

   assign req_stall  = !job_free;
   assign req_accept = req_valid && !req_stall;

   // running argmax
   assign labels_used  = (labels_ff > LABELS_CAP) ? LABELS_CAP : labels_ff;
   assign class_offset = pos_ff - POS_FIRST_CLASS;
   assign is_class     = (pos_ff >= POS_FIRST_CLASS) && (class_offset < POS_W'(labels_used));
   assign take         = is_class && ((pos_ff == POS_FIRST_CLASS)
                         || ($signed(req_channel_value) > $signed(max_ff)));
   assign max_upd      = take ? req_channel_value : max_ff;
   assign cls_upd      = take ? class_offset[CLASS_W-1:0] : cls_ff;
   assign pass         = (labels_used != '0) && (pos_ff >= POS_FIRST_CLASS)
                         && ($signed({max_upd[VALUE_W-1], max_upd})
                             > $signed({{(VALUE_W + 1 - THRESH_W){1'b0}}, thresh_ff}));
   assign job_load     = req_accept && req_row_end && pass;

   always_comb begin
      pos_in = pos_ff;
      max_in = max_ff;
      cls_in = cls_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      w_in   = w_ff;
      h_in   = h_ff;
      if (req_accept) begin
         case (pos_ff)
            POS_CENTER_X: cx_in = req_channel_value;
            POS_CENTER_Y: cy_in = req_channel_value;
            POS_WIDTH:    w_in  = req_channel_value;
            POS_HEIGHT:   h_in  = req_channel_value;
            default: ;
         endcase
         if (req_row_end) begin
            pos_in = '0;
            max_in = '0;
            cls_in = '0;
         end else begin
            pos_in = (pos_ff == POS_SATURATED) ? pos_ff : pos_ff + POS_W'(1);
            max_in = max_upd;
            cls_in = cls_upd;
         end
      end
   end

   // doubled corners from the held box
   assign cx_rel   = $signed({cx_ff[VALUE_W-1], cx_ff}) - $signed({2'b00, pad_x_ff});
   assign cy_rel   = $signed({cy_ff[VALUE_W-1], cy_ff}) - $signed({2'b00, pad_y_ff});
   assign twice_cx = $signed({cx_rel[VALUE_W], cx_rel, 1'b0});
   assign twice_cy = $signed({cy_rel[VALUE_W], cy_rel, 1'b0});
   assign size_w   = $signed({{(TWICE_W - VALUE_W){w_ff[VALUE_W-1]}}, w_ff});
   assign size_h   = $signed({{(TWICE_W - VALUE_W){h_ff[VALUE_W-1]}}, h_ff});

   always_comb begin
      job_v_in = job_load ? 1'b1 : (job_move ? 1'b0 : job_v_ff);
      job_in   = job_ff;
      if (job_load) begin
         job_in.x_near    = twice_cx - size_w;
         job_in.x_far     = twice_cx + size_w;
         job_in.y_near    = twice_cy - size_h;
         job_in.y_far     = twice_cy + size_h;
         job_in.meta.cls  = cls_upd;
         job_in.meta.conf = max_upd[CONF_W-1:0];
      end
   end

   // scale multiply
   always_comb begin
      logic signed [SCALE_W:0] scale_s;
      scale_s   = $signed({1'b0, scale_ff});
      prod_v_in = job_move ? 1'b1 : (prod_move ? 1'b0 : prod_v_ff);
      prod_in   = prod_ff;
      if (job_move) begin
         prod_in.x_near = PROD_W'($signed(job_ff.x_near) * scale_s);
         prod_in.x_far  = PROD_W'($signed(job_ff.x_far)  * scale_s);
         prod_in.y_near = PROD_W'($signed(job_ff.y_near) * scale_s);
         prod_in.y_far  = PROD_W'($signed(job_ff.y_far)  * scale_s);
         prod_in.meta   = job_ff.meta;
      end
   end

   // shift and clamp
   always_comb begin
      crn_v_in = prod_move ? 1'b1 : (crn_move ? 1'b0 : crn_v_ff);
      crn_in   = crn_ff;
      if (prod_move) begin
         crn_in.x_near = clamp_corner(prod_ff.x_near, img_w_ff);
         crn_in.x_far  = clamp_corner(prod_ff.x_far,  img_w_ff);
         crn_in.y_near = clamp_corner(prod_ff.y_near, img_h_ff);
         crn_in.y_far  = clamp_corner(prod_ff.y_far,  img_h_ff);
         crn_in.meta   = prod_ff.meta;
      end
   end

   // output beat
   always_comb begin
      rsp_v_in = crn_move ? 1'b1 : ((rsp_v_ff && !rsp_stall) ? 1'b0 : rsp_v_ff);
      left_in  = left_ff;
      top_in   = top_ff;
      bw_in    = bw_ff;
      bh_in    = bh_ff;
      meta_in  = meta_ff;
      if (crn_move) begin
         left_in = crn_ff.x_near;
         top_in  = crn_ff.y_near;
         bw_in   = span(crn_ff.x_near, crn_ff.x_far);
         bh_in   = span(crn_ff.y_near, crn_ff.y_far);
         meta_in = crn_ff.meta;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         max_ff    <= '0;
         cls_ff    <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         w_ff      <= '0;
         h_ff      <= '0;
         job_v_ff  <= 1'b0;
         prod_v_ff <= 1'b0;
         crn_v_ff  <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         max_ff    <= max_in;
         cls_ff    <= cls_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         job_v_ff  <= job_v_in;
         prod_v_ff <= prod_v_in;
         crn_v_ff  <= crn_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      prod_ff <= prod_in;
      crn_ff  <= crn_in;
      left_ff <= left_in;
      top_ff  <= top_in;
      bw_ff   <= bw_in;
      bh_ff   <= bh_in;
      meta_ff <= meta_in;
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_left_edge   = left_ff;
   assign rsp_top_edge    = top_ff;
   assign rsp_box_width   = bw_ff;
   assign rsp_box_height  = bh_ff;
   assign rsp_class_index = meta_ff.cls;
   assign rsp_confidence  = meta_ff.conf;

endmodule

[hdl/dad_checker.sv]
// Port-level checker for the anchor decoder, bound to the top level.
`include "detection_anchor_decode_defines.svh"

module dad_checker
   import dad_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [EDGE_W-1:0]         rsp_left_edge,
   input logic [EDGE_W-1:0]         rsp_top_edge,
   input logic [EDGE_W-1:0]         rsp_box_width,
   input logic [EDGE_W-1:0]         rsp_box_height,
   input logic [CLASS_W-1:0]        rsp_class_index,
   input logic [CONF_W-1:0]         rsp_confidence
);

   `DAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_left_edge) && $stable(rsp_top_edge) && $stable(rsp_box_width) && $stable(rsp_box_height) && $stable(rsp_class_index) && $stable(rsp_confidence), "stalled result beat changed")
   `DAD_ASSERT_NOW(a_conf_above_zero, rsp_valid, rsp_confidence != '0, "result beat with zero confidence")
   `DAD_ASSERT_NOW(a_no_beat_after_reset, $past(reset), !rsp_valid, "result beat straight after reset")
   `DAD_ASSERT_NOW(a_stall_only_backpressure, !rsp_stall, !req_stall, "input stalled while result side drains")

endmodule

bind detection_anchor_decode dad_checker u_dad_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for the anchor-row decoder, with a box predictor and a result scoreboard.
module testbench;
   import dad_pkg::*;

   typedef struct {
      logic [EDGE_W-1:0]  left_edge;
      logic [EDGE_W-1:0]  top_edge;
      logic [EDGE_W-1:0]  box_width;
      logic [EDGE_W-1:0]  box_height;
      logic [CLASS_W-1:0] class_index;
      logic [CONF_W-1:0]  confidence;
   } detection_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_channel_value;
   logic                      req_row_end;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [EDGE_W-1:0]         rsp_left_edge;
   logic [EDGE_W-1:0]         rsp_top_edge;
   logic [EDGE_W-1:0]         rsp_box_width;
   logic [EDGE_W-1:0]         rsp_box_height;
   logic [CLASS_W-1:0]        rsp_class_index;
   logic [CONF_W-1:0]         rsp_confidence;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DAT_W-1:0]      csr_data;

   // predictor copy of the registers
   logic [THRESH_W-1:0] threshold_q;
   logic [PAD_W-1:0]    pad_x_q;
   logic [PAD_W-1:0]    pad_y_q;
   logic [SCALE_W-1:0]  scale_q;
   logic [PIXEL_W-1:0]  width_px_q;
   logic [PIXEL_W-1:0]  height_px_q;
   logic [LABEL_W-1:0]  labels_q;

   // predictor copy of the row state
   logic [POS_W-1:0]          position_q;
   logic signed [VALUE_W-1:0] best_score_q;
   logic [CLASS_W-1:0]        best_class_q;
   logic signed [VALUE_W-1:0] centre_x_q;
   logic signed [VALUE_W-1:0] centre_y_q;
   logic signed [VALUE_W-1:0] size_w_q;
   logic signed [VALUE_W-1:0] size_h_q;

   detection_type             expected_boxes[$];
   logic signed [VALUE_W-1:0] row_values[$];
   int                        fail_count = 0;
   int                        beats_sent = 0;
   int                        send_gap_pct = 0;
   int                        rsp_stall_pct = 0;

   detection_anchor_decode dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_channel_value (req_channel_value),
      .req_row_end       (req_row_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_edge     (rsp_left_edge),
      .rsp_top_edge      (rsp_top_edge),
      .rsp_box_width     (rsp_box_width),
      .rsp_box_height    (rsp_box_height),
      .rsp_class_index   (rsp_class_index),
      .rsp_confidence    (rsp_confidence),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 300000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [EDGE_W-1:0] scale_corner(longint twice, logic [PIXEL_W-1:0] limit_px);
      longint product;
      longint ceiling;
      longint scaled;
      product = twice * longint'(scale_q);
      ceiling = longint'(limit_px) << FRAC_W;
      if (product <= 0) return '0;
      scaled = product >>> (FRAC_W + 1);
      if (scaled > ceiling) scaled = ceiling;
      return scaled[EDGE_W-1:0];
   endfunction

   function automatic void decode_beat(logic signed [VALUE_W-1:0] value, logic last);
      int                labels;
      int                pos;
      longint            cx;
      longint            cy;
      longint            w;
      longint            h;
      logic [EDGE_W-1:0] x0;
      logic [EDGE_W-1:0] x1;
      logic [EDGE_W-1:0] y0;
      logic [EDGE_W-1:0] y1;
      detection_type     box;
      labels = (labels_q > LABELS_CAP) ? MAX_LABELS : int'(labels_q);
      pos = int'(position_q);
      if (position_q == POS_CENTER_X) centre_x_q = value;
      else if (position_q == POS_CENTER_Y) centre_y_q = value;
      else if (position_q == POS_WIDTH) size_w_q = value;
      else if (position_q == POS_HEIGHT) size_h_q = value;
      else if (pos - BOX_CHANNELS < labels) begin
         if (position_q == POS_FIRST_CLASS || value > best_score_q) begin
            best_score_q = value;
            best_class_q = CLASS_W'(pos - BOX_CHANNELS);
         end
      end
      if (position_q != POS_SATURATED) position_q = position_q + 1'b1;
      if (last) begin
         if (labels > 0 && pos >= BOX_CHANNELS && longint'(best_score_q) > longint'(threshold_q)) begin
            cx = longint'(centre_x_q) - longint'(pad_x_q);
            cy = longint'(centre_y_q) - longint'(pad_y_q);
            w = longint'(size_w_q);
            h = longint'(size_h_q);
            x0 = scale_corner(2 * cx - w, width_px_q);
            x1 = scale_corner(2 * cx + w, width_px_q);
            y0 = scale_corner(2 * cy - h, height_px_q);
            y1 = scale_corner(2 * cy + h, height_px_q);
            box.left_edge = x0;
            box.top_edge = y0;
            box.box_width = (x1 > x0) ? x1 - x0 : '0;
            box.box_height = (y1 > y0) ? y1 - y0 : '0;
            box.class_index = best_class_q;
            box.confidence = best_score_q[CONF_W-1:0];
            expected_boxes = {expected_boxes, box};
         end
         position_q = '0;
         best_score_q = '0;
         best_class_q = '0;
      end
   endfunction

   function automatic void compare_field(string field, logic [EDGE_W-1:0] want,
                                         logic [EDGE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_box();
      detection_type want;
      if (expected_boxes.size() == 0) begin
         $display("%0t: unexpected result beat, expected none, actual %h %h %h %h %h %h", $time,
                  rsp_left_edge, rsp_top_edge, rsp_box_width, rsp_box_height,
                  rsp_class_index, rsp_confidence);
         fail_count++;
      end else begin
         want = expected_boxes.pop_front();
         compare_field("left_edge", want.left_edge, rsp_left_edge);
         compare_field("top_edge", want.top_edge, rsp_top_edge);
         compare_field("box_width", want.box_width, rsp_box_width);
         compare_field("box_height", want.box_height, rsp_box_height);
         compare_field("class_index", EDGE_W'(want.class_index), EDGE_W'(rsp_class_index));
         compare_field("confidence", EDGE_W'(want.confidence), EDGE_W'(rsp_confidence));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         threshold_q = RST_SCORE_THRESHOLD;
         pad_x_q = RST_PAD_OFFSET;
         pad_y_q = RST_PAD_OFFSET;
         scale_q = RST_SCALE_BACK;
         width_px_q = RST_IMAGE_SIZE;
         height_px_q = RST_IMAGE_SIZE;
         labels_q = RST_LABEL_COUNT;
         position_q = '0;
         best_score_q = '0;
         best_class_q = '0;
         centre_x_q = '0;
         centre_y_q = '0;
         size_w_q = '0;
         size_h_q = '0;
         expected_boxes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCORE_THRESHOLD: threshold_q = csr_data[THRESH_W-1:0];
               CSR_PAD_OFFSET_X:    pad_x_q = csr_data[PAD_W-1:0];
               CSR_PAD_OFFSET_Y:    pad_y_q = csr_data[PAD_W-1:0];
               CSR_SCALE_BACK:      scale_q = csr_data[SCALE_W-1:0];
               CSR_IMAGE_WIDTH:     width_px_q = csr_data[PIXEL_W-1:0];
               CSR_IMAGE_HEIGHT:    height_px_q = csr_data[PIXEL_W-1:0];
               CSR_LABEL_COUNT:     labels_q = csr_data[LABEL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) decode_beat(req_channel_value, req_row_end);
         if (rsp_valid && !rsp_stall) check_box();
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic send_beat(logic signed [VALUE_W-1:0] value, logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel_value <= value;
      req_row_end <= last;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_row();
      int count;
      count = row_values.size();
      for (int i = 0; i < count; i++) send_beat(row_values[i], i == count - 1);
      row_values.delete();
   endtask

   task automatic push_box(int cx, int cy, int w, int h);
      row_values = {row_values, cx};
      row_values = {row_values, cy};
      row_values = {row_values, w};
      row_values = {row_values, h};
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold the input idle until every result is in, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_boxes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] random_box_value(int slot);
      case ($urandom_range(9))
         0: return $urandom();
         1: return -int'($urandom_range(80 << 16));
         default: return (slot < 2) ? $urandom_range(900 << 16) : $urandom_range(300 << 16);
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_score();
      case ($urandom_range(9))
         0: return $urandom();
         1: return threshold_q;
         2: return threshold_q + 1;
         3: return -int'($urandom_range(1 << 16));
         4: return (row_values.size() > 4) ? row_values[$] : 0;
         default: return $urandom_range(2 << 16);
      endcase
   endfunction

   task automatic send_random_row();
      int labels;
      int length;
      int mode;
      labels = (labels_q > LABELS_CAP) ? MAX_LABELS : int'(labels_q);
      mode = $urandom_range(99);
      if (mode < 80)
         length = 4 + labels + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      else if (mode < 90)
         length = $urandom_range(1, 4 + labels);
      else
         length = $urandom_range(1, 6);
      for (int i = 0; i < length; i++) begin
         if (i < 4) row_values = {row_values, random_box_value(i)};
         else row_values = {row_values, random_score()};
      end
      send_row();
   endtask

   task automatic run_rows(int count);
      repeat (count) send_random_row();
   endtask

   task automatic random_settings();
      write_register(CSR_SCORE_THRESHOLD, $urandom_range(65536));
      write_register(CSR_PAD_OFFSET_X, ($urandom_range(4) == 0) ? ($urandom() & 32'h7FFF_FFFF)
                                                                : $urandom_range(100 << 16));
      write_register(CSR_PAD_OFFSET_Y, ($urandom_range(4) == 0) ? ($urandom() & 32'h7FFF_FFFF)
                                                                : $urandom_range(100 << 16));
      case ($urandom_range(2))
         0: write_register(CSR_SCALE_BACK, 65536);
         1: write_register(CSR_SCALE_BACK, $urandom_range(1, 24'hFF_FFFF));
         default: write_register(CSR_SCALE_BACK, $urandom_range(1 << 15, 3 << 16));
      endcase
      write_register(CSR_IMAGE_WIDTH, ($urandom_range(3) == 0) ? $urandom_range(1, 65535)
                                                               : $urandom_range(100, 2000));
      write_register(CSR_IMAGE_HEIGHT, ($urandom_range(3) == 0) ? $urandom_range(1, 65535)
                                                                : $urandom_range(100, 2000));
      case ($urandom_range(9))
         0: write_register(CSR_LABEL_COUNT, $urandom_range(48));
         1, 2: write_register(CSR_LABEL_COUNT, $urandom_range(9, 40));
         default: write_register(CSR_LABEL_COUNT, $urandom_range(1, 8));
      endcase
   endtask

   task automatic test_reset_defaults();
      push_box(320 << 16, 200 << 16, 100 << 16, 50 << 16);
      repeat (80) row_values = {row_values, random_score()};
      send_row();
      settle();
   endtask

   task automatic test_directed();
      write_register(CSR_LABEL_COUNT, 2);
      write_register(CSR_SCORE_THRESHOLD, 0);
      row_values = '{1, 2, 3};
      send_row();
      push_box(10 << 16, 10 << 16, 4 << 16, 4 << 16);
      send_row();
      push_box(100 << 16, 100 << 16, 20 << 16, 20 << 16);
      row_values = {row_values, 5 << 16};
      row_values = {row_values, 5 << 16};
      send_row();
      push_box(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      row_values = {row_values, 32'sh8000_0000};
      row_values = {row_values, 32'sh7FFF_FFFF};
      send_row();
      push_box(50 << 16, 50 << 16, -(10 << 16), -(10 << 16));
      row_values = {row_values, 1};
      row_values = {row_values, 0};
      send_row();
      push_box(60 << 16, 40 << 16, 8 << 16, 6 << 16);
      row_values = {row_values, -3};
      row_values = {row_values, -2};
      row_values = {row_values, 32'sh7FFF_FFFF};
      row_values = {row_values, 9};
      send_row();
      settle();
   endtask

   task automatic test_label_limits();
      write_register(CSR_LABEL_COUNT, 0);
      push_box(30 << 16, 30 << 16, 10 << 16, 10 << 16);
      repeat (3) row_values = {row_values, 1 << 20};
      send_row();
      settle();
      write_register(CSR_LABEL_COUNT, 255);
      push_box(300 << 16, 220 << 16, 64 << 16, 48 << 16);
      for (int i = 0; i < 260; i++) begin
         if (i == 127) row_values = {row_values, 40 << 16};
         else if (i >= 128) row_values = {row_values, 32'sh7FFF_FFFF};
         else row_values = {row_values, $urandom_range(1 << 20)};
      end
      send_row();
      push_box(70 << 16, 60 << 16, 12 << 16, 14 << 16);
      row_values = {row_values, 2 << 16};
      send_row();
      settle();
   endtask

   task automatic test_config_extremes();
      write_register(CSR_SCORE_THRESHOLD, 65536);
      write_register(CSR_PAD_OFFSET_X, 32'h7FFF_FFFF);
      write_register(CSR_PAD_OFFSET_Y, 32'h7FFF_FFFF);
      write_register(CSR_SCALE_BACK, 24'hFF_FFFF);
      write_register(CSR_IMAGE_WIDTH, 65535);
      write_register(CSR_IMAGE_HEIGHT, 65535);
      write_register(CSR_LABEL_COUNT, 2);
      push_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 10 << 16, 10 << 16);
      row_values = {row_values, 65536};
      row_values = {row_values, 65536};
      send_row();
      push_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      row_values = {row_values, 65537};
      row_values = {row_values, 0};
      send_row();
      run_rows(2);
      settle();
      write_register(CSR_SCORE_THRESHOLD, 0);
      write_register(CSR_PAD_OFFSET_X, 0);
      write_register(CSR_PAD_OFFSET_Y, 0);
      push_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
      row_values = {row_values, 1};
      row_values = {row_values, 1};
      send_row();
      run_rows(2);
      settle();
      write_register(CSR_SCALE_BACK, 1);
      write_register(CSR_IMAGE_WIDTH, 1);
      write_register(CSR_IMAGE_HEIGHT, 1);
      write_register(CSR_PAD_OFFSET_X, $urandom_range(8 << 16));
      write_register(CSR_PAD_OFFSET_Y, $urandom_range(8 << 16));
      push_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      row_values = {row_values, 7};
      row_values = {row_values, 7};
      send_row();
      run_rows(2);
      settle();
   endtask

   task automatic test_random();
      int gap_table[4] = '{0, 84, 0, 29};
      int stall_table[4] = '{0, 0, 84, 29};
      int first_beat;
      int phase;
      for (phase = 0; phase < 4; phase++) begin
         send_gap_pct = gap_table[phase];
         rsp_stall_pct = stall_table[phase];
         random_settings();
         first_beat = beats_sent;
         while (beats_sent - first_beat < 45) send_random_row();
         settle();
      end
      send_gap_pct = 0;
      rsp_stall_pct = 0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_channel_value <= '0;
      req_row_end <= 1'b0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SCORE_THRESHOLD;
      csr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      test_label_limits();
      test_config_extremes();
      test_random();
      settle();
      if (fail_count == 0 && expected_boxes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[detection_anchor_decode.f]
+incdir+hdl
hdl/dad_pkg.sv
hdl/detection_anchor_decode.sv
hdl/dad_checker.sv
sim/testbench.sv
